[sv/rlt_pkg.sv]
package rlt_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NumResourcesDefault = 6;
  localparam int unsigned IdWidthDefault      = 16;

  // Fixed transaction field widths.
  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned ReqIdWidth = 16;
  localparam int unsigned MaskWidth  = 6;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned StatWidth  = 2;

  // Owner value that marks a free resource.
  localparam int unsigned InvalidRequestId = 0;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_e;

  typedef enum logic [StatWidth-1:0] {
    ST_OK             = 2'd0,
    ST_ALREADY_HOLDER = 2'd1,
    ST_CONFLICT       = 2'd2,
    ST_NOT_LOCKED     = 2'd3
  } status_e;

  typedef struct packed {
    logic [CmdWidth-1:0]   command;
    logic [ReqIdWidth-1:0] request_id;
    logic [MaskWidth-1:0]  resource_mask;
    logic [IndexWidth-1:0] resource_index;
  } in_item_t;

  typedef struct packed {
    logic [StatWidth-1:0]  status;
    logic [MaskWidth-1:0]  granted_mask;
    logic [IndexWidth-1:0] conflict_index;
  } out_item_t;

endpackage

[sv/rlt_lock_core.sv]
module rlt_lock_core
  import rlt_pkg::*;
#(
  parameter int unsigned NumResources = NumResourcesDefault,
  parameter int unsigned IdWidth      = IdWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  // Only the resources that have a mask bit can be acquired.
  localparam int unsigned MaskLanes = (NumResources < MaskWidth) ? NumResources : MaskWidth;
  localparam logic [IdWidth-1:0] FreeId = IdWidth'(InvalidRequestId);

  logic [IdWidth-1:0]      owner_q [NumResources];
  logic [IdWidth-1:0]      owner_d [NumResources];
  logic [IdWidth-1:0]      req_id;
  logic [NumResources-1:0] match;
  logic [NumResources-1:0] busy;
  logic                    holds_any;
  logic                    idx_match;
  logic                    stop;
  out_item_t               result;

  // The requester ID is taken in its low IdWidth bits.
  if (IdWidth > ReqIdWidth) begin : g_id_ext
    assign req_id = {{(IdWidth - ReqIdWidth){1'b0}}, item_i.request_id};
  end else if (IdWidth == ReqIdWidth) begin : g_id_same
    assign req_id = item_i.request_id;
  end else begin : g_id_trunc
    assign req_id = item_i.request_id[IdWidth-1:0];
  end

  always_comb begin
    for (int i = 0; i < NumResources; i++) begin
      match[i] = (owner_q[i] == req_id);
      busy[i]  = (owner_q[i] != FreeId);
    end
    holds_any = |match;
    idx_match = 1'b0;
    for (int i = 0; i < NumResources; i++) begin
      if (int'(item_i.resource_index) == i) begin
        idx_match = match[i];
      end
    end
  end

  always_comb begin
    owner_d = owner_q;
    result  = '0;
    stop    = 1'b0;
    unique case (cmd_e'(item_i.command))
      CMD_ACQUIRE: begin
        if (holds_any) begin
          result.status = ST_ALREADY_HOLDER;
        end else begin
          // Lock in ascending order; the first busy resource ends the walk.
          for (int i = 0; i < MaskLanes; i++) begin
            if (item_i.resource_mask[i] && !stop) begin
              if (!busy[i]) begin
                owner_d[i]             = req_id;
                result.granted_mask[i] = 1'b1;
              end else begin
                stop                  = 1'b1;
                result.status         = ST_CONFLICT;
                result.conflict_index = IndexWidth'(i);
              end
            end
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < NumResources; i++) begin
          if (match[i]) begin
            owner_d[i] = FreeId;
          end
        end
      end
      CMD_CHECK: begin
        if (!idx_match) begin
          result.status = ST_NOT_LOCKED;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumResources; i++) begin
        owner_q[i] <= FreeId;
      end
    end else if (fire_i) begin
      owner_q <= owner_d;
    end
  end

  assign result_o = result;

endmodule

[sv/resource_lock_table_top.sv]
// Lock table for NUM_RESOURCES shared resources. Each resource holds the ID of
// its owner, and ID zero marks it free. An acquire transaction is refused with
// "already holder" when any entry equals the requester ID (so ID zero is
// refused while anything is free); otherwise it locks the masked resources in
// ascending order and stops with "conflict" at the first busy one, keeping the
// locks taken before it. A release transaction frees everything the requester
// holds, and a check transaction tells whether the requester owns one
// resource. Command code three changes nothing and returns all-zero fields.
// Every input transaction yields exactly one result transaction. The block
// takes one transaction per clock cycle unless out_stall_i holds back a full
// result register; a transaction passes through the input register and then
// the result register. That rate is set by the owner table, whose compare,
// priority pick and update all finish combinationally between the two
// registers, so each transaction sees the table as the previous one left it.
module resource_lock_table_top
  import rlt_pkg::*;
#(
  parameter int unsigned NUM_RESOURCES = NumResourcesDefault,
  parameter int unsigned ID_WIDTH      = IdWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      in_accept;

  // The held transaction moves on whenever the result register is empty or
  // its contents are being taken in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= result;
    end
  end

  // The owner table and its combinational update logic.
  rlt_lock_core #(
    .NumResources(NUM_RESOURCES),
    .IdWidth     (ID_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (s1_item_q),
    .result_o(result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[sv/rlt_checker.sv]
module rlt_checker
  import rlt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Grants come only from an acquire that got past the holder test.
  a_grant_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.granted_mask != '0) |->
      (out_item_o.status == ST_OK) || (out_item_o.status == ST_CONFLICT))
    else $error("grant reported with a refusing status");

  // A conflict index is only reported with a conflict.
  a_conflict_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.conflict_index != '0) |->
      out_item_o.status == ST_CONFLICT)
    else $error("conflict index without conflict");

  // Nothing at or above the conflicting resource is granted.
  a_conflict_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_CONFLICT) |->
      (out_item_o.granted_mask >> out_item_o.conflict_index) == '0)
    else $error("grant at or above the conflicting resource");

endmodule

bind resource_lock_table_top rlt_checker u_rlt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
